// ----- sv/wto_pkg.sv -----
// wto_pkg: shared types and constants for the wavetable oscillator
// command codes, register indexes, reset values and the frame control struct
// no dependencies
package wto_pkg;

    localparam int CMD_W     = 2;
    localparam int LEN_W     = 17;
    localparam int GAIN_W    = 16;
    localparam int GAIN_FRAC = 15;
    localparam int PHASE_W   = 32;
    localparam int ADDR_W    = 16;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RENDER = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd2;

    localparam logic REG_TABLE_LENGTH = 1'b0;
    localparam logic REG_GAIN         = 1'b1;

    localparam logic [LEN_W-1:0]  LEN_RESET  = 17'd48000;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd32768;

    typedef struct packed {
        logic start;
        logic add;
    } t_frame_ctl;

endpackage

// ----- sv/wto_table.sv -----
// wto_table: wave table memory, one write port and one registered read port
// includes write-to-read forwarding for a write in the cycle of the read
// depends on nothing but its parameters
module wto_table #(
    parameter int DEPTH = 65536,
    parameter int WIDTH = 16,
    parameter int AW    = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_we,
    input  logic [AW-1:0]           i_wr_addr,
    input  logic signed [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]           i_rd_addr,
    output logic signed [WIDTH-1:0] o_rd_data
);

    logic signed [WIDTH-1:0] r_mem [DEPTH];
    logic signed [WIDTH-1:0] r_rdata;
    logic signed [WIDTH-1:0] r_byp_data;
    logic                    r_byp_hit;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rdata    <= r_mem[i_rd_addr];
        r_byp_data <= i_wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp_hit <= 1'b0;
        end else begin
            r_byp_hit <= i_we && (i_wr_addr == i_rd_addr);
        end
    end

    // the memory returns old data on a same-address write, so forward it
    assign o_rd_data = r_byp_hit ? r_byp_data : r_rdata;

endmodule

// ----- sv/wto_mix.sv -----
// wto_mix: gain multiply stage, then prior-sample add, saturation and output register
// depends on wto_pkg
module wto_mix #(
    parameter int SW = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  wto_pkg::t_frame_ctl              i_ctl,
    input  logic signed [SW-1:0]             i_sample,
    input  logic [wto_pkg::GAIN_W-1:0]       i_gain,
    input  logic signed [SW-1:0]             i_prior_left,
    input  logic signed [SW-1:0]             i_prior_right,
    output logic                             o_ready,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic signed [SW-1:0]             o_left,
    output logic signed [SW-1:0]             o_right
);
    import wto_pkg::*;

    localparam int PW = SW + GAIN_W + 1;
    localparam int SCW = SW + 2;
    localparam int SUMW = SW + 3;

    function automatic logic signed [SW-1:0] sat(input logic signed [SUMW-1:0] v);
        logic [SUMW-SW:0] top;
        logic signed [SW-1:0] res;
        top = v[SUMW-1:SW-1];
        if ((top == '0) || (top == '1)) begin
            res = v[SW-1:0];
        end else if (v[SUMW-1]) begin
            res = {1'b1, {(SW-1){1'b0}}};
        end else begin
            res = {1'b0, {(SW-1){1'b1}}};
        end
        return res;
    endfunction

    logic                  r_v1;
    logic                  r_add1;
    logic signed [SCW-1:0] r_scaled;
    logic signed [SW-1:0]  r_pl;
    logic signed [SW-1:0]  r_pr;
    logic                  r_ov;
    logic signed [SW-1:0]  r_left;
    logic signed [SW-1:0]  r_right;

    logic                  w_adv_out;
    logic                  w_adv1;
    logic signed [PW-1:0]  w_prod;
    logic signed [PW-1:0]  w_shifted;
    logic signed [SUMW-1:0] w_sum_l;
    logic signed [SUMW-1:0] w_sum_r;

    assign w_adv_out = !r_ov || i_out_ready;
    assign w_adv1    = !r_v1 || w_adv_out;
    assign o_ready   = w_adv1;

    // floor shift: arithmetic right shift rounds toward minus infinity
    assign w_prod    = PW'(i_sample) * PW'($signed({1'b0, i_gain}));
    assign w_shifted = w_prod >>> GAIN_FRAC;

    always_comb begin
        if (r_add1) begin
            w_sum_l = SUMW'(r_scaled) + SUMW'(r_pl);
            w_sum_r = SUMW'(r_scaled) + SUMW'(r_pr);
        end else begin
            w_sum_l = SUMW'(r_scaled);
            w_sum_r = SUMW'(r_scaled);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (w_adv1) begin
                r_v1 <= i_ctl.start;
            end
            if (w_adv_out) begin
                r_ov <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1 && i_ctl.start) begin
            r_add1   <= i_ctl.add;
            r_scaled <= w_shifted[SCW-1:0];
            r_pl     <= i_prior_left;
            r_pr     <= i_prior_right;
        end
        if (w_adv_out && r_v1) begin
            r_left  <= sat(w_sum_l);
            r_right <= sat(w_sum_r);
        end
    end

    assign o_out_valid = r_ov;
    assign o_left      = r_left;
    assign o_right     = r_right;

endmodule

// ----- sv/wavetable_oscillator_unit.sv -----
// wavetable_oscillator_unit: top level of the stereo wavetable oscillator
// depends on wto_pkg, wto_table and wto_mix
//
// Accepts one transaction per clock while the output side is not stalled, and returns
// one stereo frame for each render or add command via the multiply and output registers;
// write commands store a table sample and return nothing, command 3 is dropped. The rate is
// set by the phase accumulator add-and-compare and the single-port-read wave table: the
// table is read every cycle at the index of the upcoming phase, with its read data
// registered and a same-cycle write forwarded, so back-to-back frames never wait on it. The
// table has no clear after reset; only entries that were written may be rendered.
// table_length sits at byte address 0 and gain at byte address 4 of the APB port.
module wavetable_oscillator_unit #(
    parameter int TABLE_DEPTH     = 65536,
    parameter int SAMPLE_WIDTH    = 16,
    parameter int PHASE_FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [wto_pkg::APB_AW-1:0]        paddr,
    input  logic [wto_pkg::APB_DW-1:0]        pwdata,
    output logic [wto_pkg::APB_DW-1:0]        prdata,
    output logic                              pready,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [wto_pkg::CMD_W-1:0]         i_command,
    input  logic [wto_pkg::ADDR_W-1:0]        i_table_addr,
    input  logic signed [SAMPLE_WIDTH-1:0]    i_table_data,
    input  logic [wto_pkg::PHASE_W-1:0]       i_freq_step,
    input  logic signed [SAMPLE_WIDTH-1:0]    i_prior_left,
    input  logic signed [SAMPLE_WIDTH-1:0]    i_prior_right,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]    o_left_sample,
    output logic signed [SAMPLE_WIDTH-1:0]    o_right_sample
);
    import wto_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = (LEN_W + PHASE_FRAC_BITS > PHASE_W + 1) ?
                        LEN_W + PHASE_FRAC_BITS : PHASE_W + 1;

    logic [LEN_W-1:0]   r_len;
    logic [GAIN_W-1:0]  r_gain;
    logic [PHASE_W-1:0] r_phase;
    logic [PHASE_W-1:0] n_phase;

    logic                    w_cfg_we;
    logic                    w_accept;
    logic                    w_frame;
    logic                    w_write;
    logic                    w_mix_ready;
    logic [CW-1:0]           w_next;
    logic [CW-1:0]           w_limit;
    logic [AW-1:0]           w_wr_idx;
    logic [AW-1:0]           w_rd_idx;
    logic signed [SAMPLE_WIDTH-1:0] w_sample;
    t_frame_ctl              w_ctl;

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= LEN_RESET;
            r_gain <= GAIN_RESET;
        end else if (w_cfg_we) begin
            if (paddr[2] == REG_TABLE_LENGTH) begin
                r_len <= pwdata[LEN_W-1:0];
            end else begin
                r_gain <= pwdata[GAIN_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_GAIN) ? APB_DW'(r_gain) : APB_DW'(r_len);

    // command decode
    assign o_in_ready = w_mix_ready && i_rst_n;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_frame    = w_accept && ((i_command == CMD_RENDER) || (i_command == CMD_ADD));
    assign w_write    = w_accept && (i_command == CMD_WRITE);

    assign w_ctl.start = w_frame;
    assign w_ctl.add   = (i_command == CMD_ADD);

    // phase accumulator: resets to zero at the table length, no modulo wrap
    assign w_next  = CW'(r_phase) + CW'(i_freq_step);
    assign w_limit = CW'(r_len) << PHASE_FRAC_BITS;

    always_comb begin
        n_phase = r_phase;
        if (w_frame) begin
            if (w_next >= w_limit) begin
                n_phase = '0;
            end else begin
                n_phase = w_next[PHASE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else begin
            r_phase <= n_phase;
        end
    end

    // read address follows the upcoming phase so the sample is ready with r_phase
    assign w_wr_idx = AW'(32'(i_table_addr) % TABLE_DEPTH);
    assign w_rd_idx = AW'(32'(n_phase >> PHASE_FRAC_BITS) % TABLE_DEPTH);

    wto_table #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (SAMPLE_WIDTH),
        .AW    (AW)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_we      (w_write),
        .i_wr_addr (w_wr_idx),
        .i_wr_data (i_table_data),
        .i_rd_addr (w_rd_idx),
        .o_rd_data (w_sample)
    );

    wto_mix #(
        .SW (SAMPLE_WIDTH)
    ) u_mix (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_ctl),
        .i_sample      (w_sample),
        .i_gain        (r_gain),
        .i_prior_left  (i_prior_left),
        .i_prior_right (i_prior_right),
        .o_ready       (w_mix_ready),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_left        (o_left_sample),
        .o_right       (o_right_sample)
    );

endmodule
